/* design/gcc_pkg.sv */
// ---------------------------------------------------------------------------
// gcc_pkg
// Shared types and constants for the grid component counter.
// ---------------------------------------------------------------------------
package gcc_pkg;
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int CELL_W     = 12;
   localparam int CELLS      = MAX_ROWS * MAX_COLS;
   localparam int CNT_W      = 13;
   localparam int DIM_W      = 7;
   localparam logic [CNT_W-1:0] GROUPS_MAX = 13'd8191;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef logic [CELL_W-1:0] cell_type;
endpackage

/* design/gcc_find.sv */
// ---------------------------------------------------------------------------
// gcc_find
// Parent table with root search and full path compression.
// ---------------------------------------------------------------------------
module gcc_find (
   input  logic              clock,
   input  logic              reset,
   input  logic              find_start,
   input  gcc_pkg::cell_type find_cell,
   input  logic              link_en,
   input  gcc_pkg::cell_type link_node,
   input  gcc_pkg::cell_type link_parent,
   output logic              find_done,
   output gcc_pkg::cell_type find_root,
   output logic              clr_busy
);
   import gcc_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_UP    = 6'b000100,
      S_CWAIT = 6'b001000,
      S_COMP  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   cell_type  mem [CELLS];
   cell_type  rd_ff;
   cell_type  addr_ff, addr_in;
   cell_type  start_ff, start_in;
   cell_type  root_ff, root_in;
   cell_type  clr_ff, clr_in;
   cell_type  rd_addr;
   logic      we;
   cell_type  wa, wd;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      start_in = start_ff;
      root_in  = root_ff;
      clr_in   = clr_ff;
      rd_addr  = addr_ff;
      we = 1'b0;
      wa = clr_ff;
      wd = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == cell_type'(CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (link_en) begin
               we = 1'b1;
               wa = link_node;
               wd = link_parent;
            end else if (find_start) begin
               addr_in  = find_cell;
               start_in = find_cell;
               rd_addr  = find_cell;
               state_in = S_UP;
            end
         end
         S_UP: begin
            if (rd_ff == addr_ff) begin
               root_in  = addr_ff;
               addr_in  = start_ff;
               rd_addr  = start_ff;
               state_in = S_CWAIT;
            end else begin
               addr_in = rd_ff;
               rd_addr = rd_ff;
            end
         end
         S_CWAIT: begin
            state_in = S_COMP;
         end
         S_COMP: begin
            if (addr_ff == root_ff) begin
               state_in = S_DONE;
            end else begin
               we = 1'b1;
               wa = addr_ff;
               wd = root_ff;
               addr_in  = rd_ff;
               rd_addr  = rd_ff;
               state_in = S_CWAIT;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      addr_ff  <= addr_in;
      start_ff <= start_in;
      root_ff  <= root_in;
   end

   assign find_done = (state_ff == S_DONE);
   assign find_root = root_ff;
   assign clr_busy  = (state_ff == S_CLEAR);
endmodule

/* design/grid_component_counter_unit.sv */
// ---------------------------------------------------------------------------
// grid_component_counter_unit
// Union-find group counter over a grid of on/off cells.
// ---------------------------------------------------------------------------
// A request off the grid goes straight to the response. Otherwise each on
// neighbor adds two root searches, which grow with the chain depths walked.
// Throughput: one transfer at a time; busy falls the cycle after the response.
// The parent memory walk (one read port, one write port) sets the rate.
// After reset a clearing pass initializes the parent table and the on map;
// busy stays high during it. The receiver cannot stall.
module grid_component_counter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [gcc_pkg::ROW_W-1:0]  req_cell_row,
   input  logic [gcc_pkg::COL_W-1:0]  req_cell_col,
   output logic                       rsp_valid,
   output logic [gcc_pkg::CNT_W-1:0]  rsp_group_count,
   output logic                       rsp_was_new,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [gcc_pkg::DIM_W-1:0]  csr_data
);
   import gcc_pkg::*;

   typedef enum logic [6:0] {
      T_IDLE = 7'b0000001,
      T_MARK = 7'b0000010,
      T_NB   = 7'b0000100,
      T_FA   = 7'b0001000,
      T_FB   = 7'b0010000,
      T_LINK = 7'b0100000,
      T_OUT  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] rows_ff, cols_ff;
   logic [CNT_W-1:0] groups_ff, groups_in;
   logic             fresh_ff, fresh_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       k_ff, k_in;
   cell_type         ra_ff, ra_in;
   logic             on_map [CELLS];
   logic             on_rd_ff;
   logic             on_we;
   cell_type         on_addr;
   cell_type         on_clr_ff;

   logic [DIM_W-1:0] rows_eff, cols_eff;
   logic [DIM_W:0]   nr, nc;
   logic             nb_in;
   cell_type         cur_cell, nb;
   logic             fstart, fdone, fbusy, link_en;
   cell_type         fcell, froot;

   assign rows_eff = (rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ff;
   assign cols_eff = (cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ff;
   assign cur_cell = {row_ff, col_ff};

   always_comb begin
      nr = {2'b00, row_ff};
      nc = {2'b00, col_ff};
      case (k_ff)
         2'd0: nr = nr - 1'b1;
         2'd1: nr = nr + 1'b1;
         2'd2: nc = nc - 1'b1;
         2'd3: nc = nc + 1'b1;
         default: ;
      endcase
   end
   assign nb_in = !nr[DIM_W] && !nc[DIM_W] && (nr < {1'b0, rows_eff})
                  && (nc < {1'b0, cols_eff});
   assign nb = {nr[ROW_W-1:0], nc[COL_W-1:0]};

   always_comb begin
      state_in  = state_ff;
      groups_in = groups_ff;
      fresh_in  = fresh_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      k_in      = k_ff;
      ra_in     = ra_ff;
      on_we     = 1'b0;
      on_addr   = nb;
      fstart    = 1'b0;
      fcell     = cur_cell;
      link_en   = 1'b0;
      case (state_ff)
         T_IDLE: begin
            if (start && !fbusy) begin
               row_in = req_cell_row;
               col_in = req_cell_col;
               fresh_in = 1'b0;
               on_addr = {req_cell_row, req_cell_col};
               if ({1'b0, req_cell_row} < rows_eff && {1'b0, req_cell_col} < cols_eff)
                  state_in = T_MARK;
               else
                  state_in = T_OUT;
            end
         end
         T_MARK: begin
            if (!on_rd_ff) begin
               fresh_in = 1'b1;
               on_we = 1'b1;
               on_addr = cur_cell;
               if (groups_ff < GROUPS_MAX) groups_in = groups_ff + 1'b1;
            end
            k_in = 2'd0;
            state_in = T_NB;
         end
         T_NB: begin
            if (nb_in && on_rd_ff) begin
               fstart = 1'b1;
               fcell = cur_cell;
               state_in = T_FA;
            end else if (k_ff == 2'd3) begin
               state_in = T_OUT;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = T_NB;
            end
         end
         T_FA: begin
            if (fdone) begin
               ra_in = froot;
               state_in = T_FB;
            end
         end
         T_FB: begin
            fstart = !fdone;
            fcell = nb;
            if (fdone) state_in = T_LINK;
         end
         T_LINK: begin
            if (ra_ff != froot) begin
               link_en = 1'b1;
               if (groups_ff != '0) groups_in = groups_ff - 1'b1;
            end
            if (k_ff == 2'd3) begin
               state_in = T_OUT;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = T_NB;
            end
         end
         T_OUT: state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
      if (state_in == T_NB) on_addr = nb;
   end

   // neighbor address for next cycle's read uses updated k
   cell_type on_rd_addr;
   logic [DIM_W:0] anr, anc;
   always_comb begin
      anr = {2'b00, row_ff};
      anc = {2'b00, col_ff};
      case (k_in)
         2'd0: anr = anr - 1'b1;
         2'd1: anr = anr + 1'b1;
         2'd2: anc = anc - 1'b1;
         2'd3: anc = anc + 1'b1;
         default: ;
      endcase
      on_rd_addr = (state_ff == T_IDLE) ? on_addr
                   : {anr[ROW_W-1:0], anc[COL_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (fbusy) begin
         on_map[on_clr_ff] <= 1'b0;
      end else if (on_we) begin
         on_map[cur_cell] <= 1'b1;
      end
      on_rd_ff <= on_map[on_rd_addr];
   end

   gcc_find u_find (
      .clock       (clock),
      .reset       (reset),
      .find_start  (fstart),
      .find_cell   (fcell),
      .link_en     (link_en),
      .link_node   (ra_ff),
      .link_parent (froot),
      .find_done   (fdone),
      .find_root   (froot),
      .clr_busy    (fbusy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         groups_ff <= '0;
         rows_ff   <= DIM_W'(64);
         cols_ff   <= DIM_W'(64);
         on_clr_ff <= '0;
      end else begin
         state_ff  <= state_in;
         groups_ff <= groups_in;
         if (fbusy) on_clr_ff <= on_clr_ff + 1'b1;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROWS) rows_ff <= csr_data;
            if (csr_index == CSR_COLS) cols_ff <= csr_data;
         end
      end
      fresh_ff <= fresh_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      k_ff     <= k_in;
      ra_ff    <= ra_in;
   end

   assign busy            = (state_ff != T_IDLE) || fbusy;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = (state_ff == T_OUT);
   assign rsp_group_count = groups_ff;
   assign rsp_was_new     = fresh_ff;

   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back responses");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");
   a_new_inc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_MARK && !on_rd_ff && groups_ff < GROUPS_MAX)
      |=> groups_ff == $past(groups_ff) + 1'b1) else $error("count not raised");
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Grid component counter: directed and random cell activations under several
// grid sizes, checked against an in-bench union-find predictor.
// ---------------------------------------------------------------------------
module tb_top;
   import gcc_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ROW_W-1:0]    req_cell_row = '0;
   logic [COL_W-1:0]    req_cell_col = '0;
   logic                rsp_valid;
   logic [CNT_W-1:0]    rsp_group_count;
   logic                rsp_was_new;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_ROWS;
   logic [DIM_W-1:0]    csr_data = '0;

   grid_component_counter_unit dut (.*);

   always #5 clock = ~clock;

   typedef struct packed {
      logic [CNT_W-1:0] group_count;
      logic             was_new;
   } count_rsp_type;

   cell_type         parent_mem [CELLS];
   logic             lit_map [CELLS];
   logic [CNT_W-1:0] group_total;
   logic [DIM_W-1:0] rows_cfg, cols_cfg;
   count_rsp_type    pending_counts [$];
   int               error_count = 0;
   bit               idle_on = 1'b1;

   function automatic cell_type find_root(cell_type x);
      cell_type r, nxt;
      r = x;
      while (parent_mem[r] != r) r = parent_mem[r];
      while (x != r) begin
         nxt = parent_mem[x];
         parent_mem[x] = r;
         x = nxt;
      end
      return r;
   endfunction

   function automatic count_rsp_type predict_count(int row, int col);
      int rows, cols, nr, nc;
      int dr [4] = '{-1, 1, 0, 0};
      int dc [4] = '{0, 0, -1, 1};
      cell_type me, nb, ra, rb;
      count_rsp_type res;
      rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
      cols = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
      res.was_new = 1'b0;
      if (row < rows && col < cols) begin
         me = cell_type'(row * MAX_COLS + col);
         if (!lit_map[me]) begin
            lit_map[me] = 1'b1;
            res.was_new = 1'b1;
            if (group_total < GROUPS_MAX) group_total++;
         end
         for (int k = 0; k < 4; k++) begin
            nr = row + dr[k];
            nc = col + dc[k];
            if (nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
               nb = cell_type'(nr * MAX_COLS + nc);
               if (lit_map[nb]) begin
                  ra = find_root(me);
                  rb = find_root(nb);
                  if (ra != rb) begin
                     parent_mem[ra] = rb;
                     if (group_total > 0) group_total--;
                  end
               end
            end
         end
      end
      res.group_count = group_total;
      return res;
   endfunction

   task automatic idle_gap();
      if (idle_on && $urandom_range(3) == 0)
         repeat ($urandom_range(19, 1)) @(posedge clock);
   endtask

   task automatic send_cell(int row, int col);
      idle_gap();
      start        <= 1'b1;
      req_cell_row <= ROW_W'(row);
      req_cell_col <= COL_W'(col);
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_counts.push_back(predict_count(row, col));
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_grid(logic idx, int value);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= DIM_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ROWS) rows_cfg = DIM_W'(value);
      else cols_cfg = DIM_W'(value);
   endtask

   task automatic set_grid(int rows, int cols);
      write_grid(CSR_ROWS, rows);
      write_grid(CSR_COLS, cols);
   endtask

   task automatic rand_cell(int rows, int cols);
      if ($urandom_range(9) == 0) send_cell($urandom_range(63), $urandom_range(63));
      else send_cell($urandom_range(rows - 1), $urandom_range(cols - 1));
   endtask

   always @(posedge clock) begin
      count_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_counts.size() == 0) begin
            $error("unexpected transfer: group_count %0d", rsp_group_count);
            error_count++;
         end else begin
            want = pending_counts.pop_front();
            if (rsp_group_count !== want.group_count) begin
               $error("group_count exp %0d got %0d", want.group_count, rsp_group_count);
               error_count++;
            end
            if (rsp_was_new !== want.was_new) begin
               $error("was_new exp %0d got %0d", want.was_new, rsp_was_new);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_cell(0, 0);
      send_cell(0, 0);
      send_cell(63, 63);
      send_cell(0, 63);
      send_cell(63, 0);
      send_cell(0, 1);
      send_cell(1, 0);
      send_cell(1, 1);
      send_cell(62, 63);
      send_cell(63, 62);
      send_cell(32, 21);
      send_cell(31, 42);
      send_cell(32, 42);
      send_cell(31, 21);
      set_grid(1, 1);
      send_cell(0, 0);
      send_cell(1, 0);
      send_cell(0, 1);
      set_grid(0, 0);
      send_cell(0, 0);
      set_grid(127, 127);
      send_cell(42, 21);
      send_cell(21, 42);
   endtask

   task automatic test_random_grid(int rows, int cols, int n);
      set_grid(rows, cols);
      repeat (n) rand_cell(rows, cols);
   endtask

   task automatic test_resize_kept_state();
      set_grid(8, 8);
      repeat (40) rand_cell(8, 8);
      set_grid(64, 64);
      repeat (60) rand_cell(10, 10);
   endtask

   initial begin
      rows_cfg    = 7'd64;
      cols_cfg    = 7'd64;
      group_total = '0;
      for (int i = 0; i < CELLS; i++) begin
         parent_mem[i] = cell_type'(i);
         lit_map[i]    = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_grid(4, 5, 150);
      test_random_grid(64, 64, 450);
      test_random_grid(16, 64, 300);
      test_random_grid(64, 1, 150);
      test_resize_kept_state();
      test_random_grid(1, 64, 150);
      idle_on = 1'b0;
      test_random_grid(64, 64, 200);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule

/* grid_component_counter_unit.f */
design/gcc_pkg.sv
design/gcc_find.sv
design/grid_component_counter_unit.sv
dv/tb_top.sv
